// ----- rtl/scd_pkg.sv -----
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants of the sector cache clock directory
// Holds the command codes, the fixed port widths and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package scd_pkg;

    // Command codes of the input item
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // Fixed port widths
    localparam int SLOT_W   = 6;
    localparam int SECTOR_W = 32;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LOOKUP,
        OP_HIT,
        OP_SWEEP,
        OP_FILL,
        OP_FL_ADV,
        OP_FL_EMIT,
        OP_EMPTY
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   rd_hand;   // read tag memory at the clock hand
        logic   use_hand;  // new entry goes to the clock hand slot
    } ctl_t;

    typedef struct packed {
        logic match;        // valid slot with matching tag under compare
        logic scan_end;     // last slot under compare
        logic empty_found;  // an empty slot was seen during lookup
        logic ref_at_hand;  // reference bit at the clock hand
        logic fl_here;      // slot at the scan index is valid and dirty
        logic cnt_zero;     // no dirty slots
        logic cnt_one;      // exactly one dirty slot
        logic out_free;     // output register can take a result this cycle
    } sts_t;

endpackage

// ----- rtl/sector_cache_clock_directory.sv -----
// ----------------------------------------------------------------------------
// sector_cache_clock_directory: clock second-chance tag directory
// Fully associative sector cache directory with valid, reference and dirty
// bits per slot, a tag memory and a clock hand for victim choice.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, cmd, sector) takes one item at a time:
//   read, write or flush. in_stall is high while an item is in progress.
//   Output channel (out_valid/out_stall) carries results; last marks the
//   final result of an item. Read and write give one result, flush gives one
//   result per dirty slot in ascending slot order, or a single empty result.
//   A read or write scans the tag memory one slot per cycle through its
//   single read port, and stops early on a hit. A miss with every slot
//   valid adds the clock sweep, one slot per cycle. A flush steps over clean
//   slots one per cycle and stops on each dirty slot until the output
//   register can take its result; an empty flush scans no slots.
//   Results wait in an output register; while the receiver stalls, the block
//   holds the result and pauses before producing the next one. The next item
//   is taken as soon as the last result of the previous one is registered.
//   Reset clears all valid, reference and dirty bits and the clock hand; no
//   clearing pass runs, so items are accepted right after reset.
// ----------------------------------------------------------------------------
module sector_cache_clock_directory
#(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   cmd,
    input  logic [scd_pkg::SECTOR_W-1:0] sector,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic [scd_pkg::SLOT_W-1:0]   slot,
    output logic                         fill_needed,
    output logic                         writeback_valid,
    output logic [scd_pkg::SECTOR_W-1:0] writeback_sector,
    output logic                         last
);
    import scd_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // Sequencer
    scd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Slot state, tags and results
    scd_datapath
    #(
        .ENTRIES     (ENTRIES),
        .SECTOR_BITS (SECTOR_BITS)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sector           (sector),
        .ctl              (ctl),
        .sts              (sts),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit),
        .slot             (slot),
        .fill_needed      (fill_needed),
        .writeback_valid  (writeback_valid),
        .writeback_sector (writeback_sector),
        .last             (last)
    );

endmodule

// ----- rtl/scd_ctrl.sv -----
// ----------------------------------------------------------------------------
// scd_ctrl: sequencer of the sector cache clock directory
// Accepts one item at a time and steps the datapath through lookup,
// clock sweep, entry fill and flush scan.
// ----------------------------------------------------------------------------
module scd_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    cmd,
    input  scd_pkg::sts_t sts,
    output scd_pkg::ctl_t ctl
);
    import scd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_MISS,
        S_HIT,
        S_SWEEP,
        S_VICTIM,
        S_FL_SCAN,
        S_FL_EMIT,
        S_EMPTY
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a new item only when no item is in progress
    assign in_stall = (state_reg != S_IDLE);

    // Next state and datapath command
    always_comb
    begin
        state_next   = state_reg;
        ctl.op       = OP_NONE;
        ctl.rd_hand  = 1'b0;
        ctl.use_hand = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        CMD_READ, CMD_WRITE:
                        begin
                            ctl.op     = OP_LOAD;
                            state_next = S_LOOKUP;
                        end
                        CMD_FLUSH:
                        begin
                            ctl.op = OP_LOAD;
                            if (sts.cnt_zero)
                                state_next = S_EMPTY;
                            else
                                state_next = S_FL_SCAN;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                ctl.op = OP_LOOKUP;
                if (sts.match)
                    state_next = S_HIT;
                else if (sts.scan_end)
                    state_next = S_MISS;
            end
            S_HIT:
            begin
                if (sts.out_free)
                begin
                    ctl.op     = OP_HIT;
                    state_next = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (!sts.empty_found)
                    state_next = S_SWEEP;
                else if (sts.out_free)
                begin
                    ctl.op     = OP_FILL;
                    state_next = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                ctl.op      = OP_SWEEP;
                ctl.rd_hand = 1'b1;
                if (!sts.ref_at_hand)
                    state_next = S_VICTIM;
            end
            S_VICTIM:
            begin
                ctl.rd_hand  = 1'b1;
                ctl.use_hand = 1'b1;
                if (sts.out_free)
                begin
                    ctl.op     = OP_FILL;
                    state_next = S_IDLE;
                end
            end
            S_FL_SCAN:
            begin
                if (sts.fl_here)
                    state_next = S_FL_EMIT;
                else
                    ctl.op = OP_FL_ADV;
            end
            S_FL_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.op = OP_FL_EMIT;
                    if (sts.cnt_one)
                        state_next = S_IDLE;
                    else
                        state_next = S_FL_SCAN;
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    ctl.op     = OP_EMPTY;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/scd_datapath.sv -----
// ----------------------------------------------------------------------------
// scd_datapath: slot state, tag memory and result register
// Keeps valid, reference and dirty bits, the clock hand, a dirty count and
// the sector tags, and performs the step that the controller commands.
// ----------------------------------------------------------------------------
module scd_datapath
#(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [1:0]                     cmd,
    input  logic [scd_pkg::SECTOR_W-1:0]   sector,
    input  scd_pkg::ctl_t                  ctl,
    output scd_pkg::sts_t                  sts,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic [scd_pkg::SLOT_W-1:0]     slot,
    output logic                           fill_needed,
    output logic                           writeback_valid,
    output logic [scd_pkg::SECTOR_W-1:0]   writeback_sector,
    output logic                           last
);
    import scd_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int TAG_W = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    // Slot state
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] ref_reg, ref_next;
    logic [ENTRIES-1:0] dirty_reg, dirty_next;
    logic [IDX_W-1:0]   hand_reg, hand_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // Scan control
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]   empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]   sel_reg, sel_next;
    logic               is_write_reg, is_write_next;
    logic [TAG_W-1:0]   sec_reg, sec_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic                hit_reg, hit_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                fill_reg, fill_next;
    logic                wbv_reg, wbv_next;
    logic [SECTOR_W-1:0] wbs_reg, wbs_next;
    logic                last_reg, last_next;

    // Tag memory
    logic [TAG_W-1:0]    tag_mem [ENTRIES];
    logic [TAG_W-1:0]    tag_q;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;

    logic                chk_hit;
    logic                idx_last;
    logic                hand_last;
    logic [IDX_W-1:0]    new_slot;
    logic                victim_dirty;

    assign rd_addr      = ctl.rd_hand ? hand_reg : idx_reg;
    assign idx_last     = (idx_reg == IDX_LAST);
    assign hand_last    = (hand_reg == IDX_LAST);
    assign chk_hit      = chk_vld_reg && valid_reg[chk_idx_reg] && (tag_q == sec_reg);
    assign new_slot     = ctl.use_hand ? hand_reg : empty_idx_reg;
    assign victim_dirty = valid_reg[new_slot] & dirty_reg[new_slot];

    // Status toward the controller
    always_comb
    begin
        sts.match       = chk_hit;
        sts.scan_end    = chk_vld_reg && (chk_idx_reg == IDX_LAST);
        sts.empty_found = empty_found_reg;
        sts.ref_at_hand = ref_reg[hand_reg];
        sts.fl_here     = valid_reg[idx_reg] & dirty_reg[idx_reg];
        sts.cnt_zero    = (cnt_reg == '0);
        sts.cnt_one     = (cnt_reg == CNT_W'(1));
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    // Execute the commanded step
    always_comb
    begin
        valid_next       = valid_reg;
        ref_next         = ref_reg;
        dirty_next       = dirty_reg;
        hand_next        = hand_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        chk_vld_next     = chk_vld_reg;
        chk_idx_next     = chk_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        sel_next         = sel_reg;
        is_write_next    = is_write_reg;
        sec_next         = sec_reg;
        mem_we           = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;
        hit_next         = hit_reg;
        slot_next        = slot_reg;
        fill_next        = fill_reg;
        wbv_next         = wbv_reg;
        wbs_next         = wbs_reg;
        last_next        = last_reg;
        case (ctl.op)
            OP_LOAD:
            begin
                is_write_next    = (cmd == CMD_WRITE);
                sec_next         = sector[TAG_W-1:0];
                idx_next         = '0;
                chk_vld_next     = 1'b0;
                empty_found_next = 1'b0;
            end
            OP_LOOKUP:
            begin
                if (!idx_last)
                    idx_next = idx_reg + 1'b1;
                chk_vld_next = 1'b1;
                chk_idx_next = idx_reg;
                if (chk_vld_reg && !valid_reg[chk_idx_reg] && !empty_found_reg)
                begin
                    empty_found_next = 1'b1;
                    empty_idx_next   = chk_idx_reg;
                end
                if (chk_hit)
                    sel_next = chk_idx_reg;
            end
            OP_HIT:
            begin
                ref_next[sel_reg] = 1'b1;
                if (is_write_reg && !dirty_reg[sel_reg])
                begin
                    dirty_next[sel_reg] = 1'b1;
                    cnt_next            = cnt_reg + 1'b1;
                end
                out_valid_next = 1'b1;
                hit_next       = 1'b1;
                slot_next      = SLOT_W'(sel_reg);
                fill_next      = 1'b0;
                wbv_next       = 1'b0;
                wbs_next       = '0;
                last_next      = 1'b1;
            end
            OP_SWEEP:
            begin
                // Clear the reference bit and advance past a referenced slot
                if (ref_reg[hand_reg])
                begin
                    ref_next[hand_reg] = 1'b0;
                    hand_next          = hand_last ? '0 : hand_reg + 1'b1;
                end
            end
            OP_FILL:
            begin
                valid_next[new_slot] = 1'b1;
                ref_next[new_slot]   = 1'b1;
                dirty_next[new_slot] = is_write_reg;
                mem_we               = 1'b1;
                cnt_next = cnt_reg + CNT_W'(is_write_reg) - CNT_W'(victim_dirty);
                out_valid_next = 1'b1;
                hit_next       = 1'b0;
                slot_next      = SLOT_W'(new_slot);
                fill_next      = !is_write_reg;
                wbv_next       = victim_dirty;
                wbs_next       = victim_dirty ? SECTOR_W'(tag_q) : '0;
                last_next      = 1'b1;
            end
            OP_FL_ADV:
            begin
                if (!idx_last)
                    idx_next = idx_reg + 1'b1;
            end
            OP_FL_EMIT:
            begin
                dirty_next[idx_reg] = 1'b0;
                cnt_next            = cnt_reg - 1'b1;
                if (!idx_last)
                    idx_next = idx_reg + 1'b1;
                out_valid_next = 1'b1;
                hit_next       = 1'b0;
                slot_next      = SLOT_W'(idx_reg);
                fill_next      = 1'b0;
                wbv_next       = 1'b1;
                wbs_next       = SECTOR_W'(tag_q);
                last_next      = (cnt_reg == CNT_W'(1));
            end
            OP_EMPTY:
            begin
                out_valid_next = 1'b1;
                hit_next       = 1'b0;
                slot_next      = '0;
                fill_next      = 1'b0;
                wbv_next       = 1'b0;
                wbs_next       = '0;
                last_next      = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            ref_reg         <= '0;
            dirty_reg       <= '0;
            hand_reg        <= '0;
            cnt_reg         <= '0;
            chk_vld_reg     <= 1'b0;
            empty_found_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            ref_reg         <= ref_next;
            dirty_reg       <= dirty_next;
            hand_reg        <= hand_next;
            cnt_reg         <= cnt_next;
            chk_vld_reg     <= chk_vld_next;
            empty_found_reg <= empty_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        chk_idx_reg   <= chk_idx_next;
        empty_idx_reg <= empty_idx_next;
        sel_reg       <= sel_next;
        is_write_reg  <= is_write_next;
        sec_reg       <= sec_next;
        hit_reg       <= hit_next;
        slot_reg      <= slot_next;
        fill_reg      <= fill_next;
        wbv_reg       <= wbv_next;
        wbs_reg       <= wbs_next;
        last_reg      <= last_next;
    end

    // Tag memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tag_mem[new_slot] <= sec_reg;
        tag_q <= tag_mem[rd_addr];
    end

    assign out_valid        = out_valid_reg;
    assign hit              = hit_reg;
    assign slot             = slot_reg;
    assign fill_needed      = fill_reg;
    assign writeback_valid  = wbv_reg;
    assign writeback_sector = wbs_reg;
    assign last             = last_reg;

`ifndef SYNTHESIS
    // Dirty count tracks the valid dirty slots
    a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == CNT_W'($countones(valid_reg & dirty_reg)))
        else $error("dirty count out of step with dirty bits");

    // A dirty slot is always valid
    a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (dirty_reg & ~valid_reg) == '0)
        else $error("dirty bit set on an empty slot");

    // Slots never become empty once filled
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(valid_reg) & ~valid_reg) == '0)
        else $error("valid bit cleared");

    // Clock hand stays within the slot range
    a_hand_range: assert property (@(posedge clk) disable iff (!rst_n)
        hand_reg <= IDX_LAST)
        else $error("clock hand out of range");
`endif

endmodule
